[rtl/scheduled_message_timer_table_core_defines.svh]
// assertion macros used by the checker file
`ifndef SCHEDULED_MESSAGE_TIMER_TABLE_CORE_DEFINES_SVH
`define SCHEDULED_MESSAGE_TIMER_TABLE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SMTT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SMTT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/smtt_pkg.sv]
`default_nettype none
package smtt_pkg;

  localparam int DELAY_W = 31;
  localparam int MSG_ID_W = 16;
  localparam int LIMIT_W = 6;
  localparam int COUNT_W = 6;

  // operation codes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_SCHED  = 3'd1;
  localparam logic [2:0] OP_CANCEL = 3'd2;
  localparam logic [2:0] OP_EXISTS = 3'd3;
  localparam logic [2:0] OP_COUNT  = 3'd4;
  localparam logic [2:0] OP_LIST   = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_POST      = 3'd0;
  localparam logic [2:0] KIND_HOUSEKEEP = 3'd1;
  localparam logic [2:0] KIND_DONE      = 3'd2;
  localparam logic [2:0] KIND_FULL      = 3'd3;
  localparam logic [2:0] KIND_LISTED    = 3'd4;

  typedef struct packed {
    logic [2:0]          op;
    logic                core;
    logic [DELAY_W-1:0]  delay_ms;
    logic [MSG_ID_W-1:0] msg_id;
    logic [LIMIT_W-1:0]  list_limit;
  } cmd_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic                core_res;
    logic [MSG_ID_W-1:0] msg_id_res;
    logic                flag;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } res_t;

endpackage
`default_nettype wire

[rtl/scheduled_message_timer_table_core.sv]
`default_nettype none
// One-shot timer table. Pulse start with a command while busy is low; busy
// drops in the cycle that carries the item's final beat (last set). Result
// beats appear on result for a single cycle each, qualified by strobe, and
// cannot be held off by the receiver. Every operation but an unused op code
// walks the slot table one slot per cycle through the single slot memory
// and one shared decrement/compare unit. The next command is taken once busy
// is low again. Up to one beat comes out per cycle.
module scheduled_message_timer_table_core import smtt_pkg::*; #(
  parameter int SLOTS = 32,
  parameter int HOUSEKEEP_BITS = 4,
  parameter int ID_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd,
  output logic      strobe,
  output res_t      result
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IW = $clog2(SLOTS + 1);
  localparam int DW = DELAY_W + 1 + ID_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_HK   = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                    state;
  cmd_t                      cmd_q;
  logic [SLOTS-1:0]          slot_busy;
  logic [IW-1:0]             idx;
  logic [IW-1:0]             scan_end;
  logic                      p1_valid;
  logic [AW-1:0]             p1_idx;
  logic [COUNT_W-1:0]        cnt;
  logic                      flag;
  logic                      found;
  logic [HOUSEKEEP_BITS-1:0] hk;
  logic [HOUSEKEEP_BITS-1:0] hk_next;

  logic [AW-1:0]      idx_a;
  logic               scan_go;
  logic [ID_BITS-1:0] key_id;

  // slot memory signals
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DW-1:0]      ram_wdata;
  logic [DW-1:0]      ram_rdata;
  logic [DELAY_W-1:0] rd_rem;
  logic               rd_core;
  logic [ID_BITS-1:0] rd_id;

  // shared unit outputs
  logic [DELAY_W-1:0] rem_dec;
  logic               p1_busy;
  logic               p1_match;
  logic               tick_live;
  logic               tick_fire;

  logic emit;
  res_t emit_res;

  assign busy    = (state != ST_IDLE);
  assign idx_a   = idx[AW-1:0];
  assign scan_go = (idx < scan_end);
  assign key_id  = ID_BITS'(cmd_q.msg_id);
  assign hk_next = hk + 1'b1;

  assign {rd_rem, rd_core, rd_id} = ram_rdata;

  smtt_ram #(
    .WIDTH(DW),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_a),
    .rdata(ram_rdata)
  );

  // decrement and compare on the slot read last cycle
  always_comb begin
    p1_busy   = slot_busy[p1_idx];
    rem_dec   = rd_rem - 1'b1;
    p1_match  = p1_busy && (rd_id == key_id);
    tick_live = p1_busy && (rd_rem != '0);
    tick_fire = tick_live && (rem_dec == '0);
  end

  // slot memory write: schedule fill or tick write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p1_idx;
    ram_wdata = {rem_dec, rd_core, rd_id};
    if (state == ST_SCAN && cmd_q.op == OP_SCHED && scan_go && !slot_busy[idx_a]) begin
      ram_we    = 1'b1;
      ram_waddr = idx_a;
      ram_wdata = {cmd_q.delay_ms, cmd_q.core, key_id};
    end else if (state == ST_SCAN && p1_valid && cmd_q.op == OP_TICK && tick_live) begin
      ram_we = 1'b1;
    end
  end

  // result beat selection
  always_comb begin
    emit     = 1'b0;
    emit_res = '0;
    case (state)
      ST_SCAN: begin
        if (p1_valid && cmd_q.op == OP_TICK && tick_fire) begin
          emit                = 1'b1;
          emit_res.kind       = KIND_POST;
          emit_res.core_res   = rd_core;
          emit_res.msg_id_res = MSG_ID_W'(rd_id);
        end else if (p1_valid && cmd_q.op == OP_LIST && p1_busy) begin
          emit                = 1'b1;
          emit_res.kind       = KIND_LISTED;
          emit_res.msg_id_res = MSG_ID_W'(rd_id);
        end
      end
      ST_HK: begin
        if (hk_next == '0) begin
          emit          = 1'b1;
          emit_res.kind = KIND_HOUSEKEEP;
        end
      end
      ST_DONE: begin
        emit           = 1'b1;
        emit_res.kind  = (cmd_q.op == OP_SCHED && !found) ? KIND_FULL : KIND_DONE;
        emit_res.flag  = flag;
        emit_res.count = cnt;
        emit_res.last  = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // sequencer and slot walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      slot_busy <= '0;
      hk        <= '0;
      p1_valid  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            idx   <= '0;
            cnt   <= '0;
            flag  <= 1'b0;
            found <= 1'b0;
            state <= ST_SCAN;
            if (cmd.op == OP_LIST) begin
              if (int'(cmd.list_limit) >= SLOTS) begin
                scan_end <= IW'(SLOTS);
              end else begin
                scan_end <= IW'(cmd.list_limit);
              end
            end else if (cmd.op == OP_TICK || cmd.op == OP_SCHED || cmd.op == OP_CANCEL ||
                         cmd.op == OP_EXISTS || cmd.op == OP_COUNT) begin
              scan_end <= IW'(SLOTS);
            end else begin
              scan_end <= '0;
            end
          end
        end
        ST_SCAN: begin
          // issue side
          if (scan_go) begin
            idx <= idx + 1'b1;
            if (cmd_q.op == OP_SCHED) begin
              if (!slot_busy[idx_a]) begin
                slot_busy[idx_a] <= 1'b1;
                found            <= 1'b1;
                state            <= ST_DONE;
              end
            end else begin
              p1_valid <= 1'b1;
              p1_idx   <= idx_a;
            end
          end else begin
            p1_valid <= 1'b0;
            if (!p1_valid) begin
              state <= (cmd_q.op == OP_TICK) ? ST_HK : ST_DONE;
            end
          end
          // evaluate side
          if (p1_valid) begin
            case (cmd_q.op)
              OP_TICK: begin
                if (tick_fire) begin
                  slot_busy[p1_idx] <= 1'b0;
                end
              end
              OP_CANCEL: begin
                if (p1_match) begin
                  slot_busy[p1_idx] <= 1'b0;
                  cnt               <= cnt + 1'b1;
                end
              end
              OP_EXISTS: begin
                if (p1_match) begin
                  flag <= 1'b1;
                end
              end
              OP_COUNT: begin
                if (p1_busy) begin
                  cnt <= cnt + 1'b1;
                end
              end
              OP_LIST: begin
                if (p1_busy) begin
                  cnt  <= cnt + 1'b1;
                  flag <= 1'b1;
                end
              end
              default: begin
                flag <= flag;
              end
            endcase
          end
        end
        ST_HK: begin
          hk    <= hk_next;
          state <= ST_DONE;
        end
        ST_DONE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    result <= emit_res;
  end

endmodule
`default_nettype wire

[rtl/smtt_ram.sv]
`default_nettype none
module smtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/smtt_checker.sv]
`default_nettype none
`include "scheduled_message_timer_table_core_defines.svh"
module smtt_checker import smtt_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire cmd_t cmd,
  input wire logic strobe,
  input wire res_t result
);

  // an accepted command keeps the block busy
  `SMTT_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "accept did not raise busy")

  // the final beat of an item ends the busy period
  `SMTT_ASSERT_IMP(a_last_idle, clk, rst, strobe && result.last, !busy, "last beat while busy")

  // earlier beats only while the item is still running
  `SMTT_ASSERT_IMP(a_more_busy, clk, rst, strobe && !result.last, busy, "beat after item end")

  // busy only drops together with a final beat
  `SMTT_ASSERT_IMP(a_fall_last, clk, rst, $fell(busy), strobe && result.last,
                   "busy dropped without final beat")

endmodule

bind scheduled_message_timer_table_core smtt_checker u_smtt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .cmd   (cmd),
  .strobe(strobe),
  .result(result)
);
`default_nettype wire

[bench/testbench.sv]
module testbench;
  import smtt_pkg::*;

  localparam int SLOTS = 32;

  // op codes the block does not define, answered with a bare done beat
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic strobe;
  res_t result;

  // expectation typed into a directed row, travels with the command
  logic cmd_typed;
  res_t cmd_want;

  int idle_pct;
  int mismatch_count;

  // shadow copy of the timer table
  logic              tt_busy [SLOTS];
  logic [30:0]       tt_left [SLOTS];
  logic              tt_core [SLOTS];
  logic [15:0]       tt_id   [SLOTS];
  logic [3:0]        hk_phase;

  res_t due_beats[$];
  res_t due_head;

  typedef struct {
    cmd_t c;
    int   reps;
    bit   typed;
    res_t want;
  } stim_row_t;

  stim_row_t plan[$];

  scheduled_message_timer_table_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic res_t mk_beat(logic [2:0] kind, logic core, logic [15:0] id,
                                   logic flag, int cnt, logic last);
    res_t r;
    r.kind       = kind;
    r.core_res   = core;
    r.msg_id_res = id;
    r.flag       = flag;
    r.count      = 6'(cnt);
    r.last       = last;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic timer_table_reset();
    for (int i = 0; i < SLOTS; i++) begin
      tt_busy[i] = 1'b0;
      tt_left[i] = '0;
      tt_core[i] = 1'b0;
      tt_id[i]   = '0;
    end
    hk_phase = '0;
  endtask

  // work out the beats one command causes and queue them
  task automatic timer_table_step(input cmd_t c);
    int   cnt;
    int   lim;
    int   slot;
    logic flag;
    res_t tail;
    cnt  = 0;
    flag = 1'b0;
    slot = SLOTS;
    case (c.op)
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tt_busy[i] && tt_left[i] != '0) begin
            tt_left[i] = tt_left[i] - 1'b1;
            if (tt_left[i] == '0) begin
              due_beats.push_back(mk_beat(KIND_POST, tt_core[i], tt_id[i], 1'b0, 0, 1'b0));
              tt_busy[i] = 1'b0;
            end
          end
        end
        hk_phase = hk_phase + 1'b1;
        if (hk_phase == '0)
          due_beats.push_back(mk_beat(KIND_HOUSEKEEP, 1'b0, '0, 1'b0, 0, 1'b0));
        due_beats.push_back(mk_beat(KIND_DONE, 1'b0, '0, 1'b0, 0, 1'b0));
      end
      OP_SCHED: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!tt_busy[i] && slot == SLOTS) slot = i;
        end
        if (slot < SLOTS) begin
          tt_busy[slot] = 1'b1;
          tt_left[slot] = c.delay_ms;
          tt_core[slot] = c.core;
          tt_id[slot]   = c.msg_id;
        end
        due_beats.push_back(mk_beat(slot < SLOTS ? KIND_DONE : KIND_FULL,
                                    1'b0, '0, 1'b0, 0, 1'b0));
      end
      OP_CANCEL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tt_busy[i] && tt_id[i] == c.msg_id) begin
            tt_busy[i] = 1'b0;
            cnt++;
          end
        end
        due_beats.push_back(mk_beat(KIND_DONE, 1'b0, '0, 1'b0, cnt, 1'b0));
      end
      OP_EXISTS: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tt_busy[i] && tt_id[i] == c.msg_id) flag = 1'b1;
        end
        due_beats.push_back(mk_beat(KIND_DONE, 1'b0, '0, flag, 0, 1'b0));
      end
      OP_COUNT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tt_busy[i]) cnt++;
        end
        due_beats.push_back(mk_beat(KIND_DONE, 1'b0, '0, 1'b0, cnt, 1'b0));
      end
      OP_LIST: begin
        // scan length saturates at the table size
        lim = (int'(c.list_limit) > SLOTS) ? SLOTS : int'(c.list_limit);
        for (int i = 0; i < lim; i++) begin
          if (tt_busy[i]) begin
            due_beats.push_back(mk_beat(KIND_LISTED, 1'b0, tt_id[i], 1'b0, 0, 1'b0));
            cnt++;
            flag = 1'b1;
          end
        end
        due_beats.push_back(mk_beat(KIND_DONE, 1'b0, '0, flag, cnt, 1'b0));
      end
      default: begin
        due_beats.push_back(mk_beat(KIND_DONE, 1'b0, '0, 1'b0, 0, 1'b0));
      end
    endcase
    // final beat of the command carries last
    tail = due_beats.pop_back();
    tail.last = 1'b1;
    due_beats.push_back(tail);
  endtask

  task automatic check_beat(input res_t got, input res_t want);
    string bad;
    bad = "";
    if (got.kind !== want.kind)             bad = {bad, " kind"};
    if (got.core_res !== want.core_res)     bad = {bad, " core_res"};
    if (got.msg_id_res !== want.msg_id_res) bad = {bad, " msg_id_res"};
    if (got.flag !== want.flag)             bad = {bad, " flag"};
    if (got.count !== want.count)           bad = {bad, " count"};
    if (got.last !== want.last)             bad = {bad, " last"};
    if (bad != "")
      report_mismatch($sformatf("bad%s: got %h want %h", bad, got, want));
  endtask

  // check beats first, then queue what a newly accepted command causes
  always @(posedge clk) begin
    if (!rst) begin
      if ($isunknown(strobe)) begin
        report_mismatch("strobe unknown");
      end else if (strobe) begin
        if (due_beats.size() == 0) begin
          report_mismatch($sformatf("beat with nothing due: %h", result));
        end else begin
          due_head = due_beats.pop_front();
          check_beat(result, due_head);
        end
      end
      if (start && !busy) begin
        timer_table_step(cmd);
        if (cmd_typed) begin
          void'(due_beats.pop_back());
          due_beats.push_back(cmd_want);
        end
      end
    end
  end

  // present one command, with random sender gaps, until it is taken
  task automatic send_cmd(input cmd_t c, input bit typed, input res_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    cmd       <= c;
    cmd_typed <= typed;
    cmd_want  <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic void add_row(logic [2:0] op, logic core, logic [30:0] delay,
                                  logic [15:0] id, logic [5:0] lim, int reps,
                                  bit typed, res_t want);
    stim_row_t r;
    r.c.op         = op;
    r.c.core       = core;
    r.c.delay_ms   = delay;
    r.c.msg_id     = id;
    r.c.list_limit = lim;
    r.reps         = reps;
    r.typed        = typed;
    r.want         = want;
    plan.push_back(r);
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    int   dsel;
    pick = $urandom_range(99);
    dsel = $urandom_range(9);
    if (pick < 34)      c.op = OP_TICK;
    else if (pick < 64) c.op = OP_SCHED;
    else if (pick < 72) c.op = OP_CANCEL;
    else if (pick < 80) c.op = OP_EXISTS;
    else if (pick < 85) c.op = OP_COUNT;
    else if (pick < 95) c.op = OP_LIST;
    else                c.op = pick[0] ? OP_SPARE_6 : OP_SPARE_7;
    c.core = 1'($urandom_range(1));
    // mostly short delays so slots fire; some held forever or very long
    if (dsel == 0)      c.delay_ms = '0;
    else if (dsel == 1) c.delay_ms = 31'($urandom);
    else if (dsel < 4)  c.delay_ms = 31'($urandom_range(60, 9));
    else                c.delay_ms = 31'($urandom_range(8, 1));
    // small id pool so cancel and exists hit often
    if ($urandom_range(3) == 0) c.msg_id = 16'($urandom);
    else                        c.msg_id = {13'h0C35, 3'($urandom_range(7))};
    c.list_limit = 6'($urandom_range(63));
    return c;
  endfunction

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    cmd            = '0;
    cmd_typed      = 1'b0;
    cmd_want       = '0;
    idle_pct       = 6;
    mismatch_count = 0;
    timer_table_reset();

    // empty table, extremes and spare op codes
    add_row(OP_COUNT,   1'b0, '0, '0, '0, 1, 1,
            mk_beat(KIND_DONE, 1'b0, '0, 1'b0, 0, 1'b1));
    add_row(OP_EXISTS,  1'b0, '0, '0, '0, 1, 1,
            mk_beat(KIND_DONE, 1'b0, '0, 1'b0, 0, 1'b1));
    add_row(OP_LIST,    1'b0, '0, '0, '1, 1, 1,
            mk_beat(KIND_DONE, 1'b0, '0, 1'b0, 0, 1'b1));
    add_row(OP_SPARE_6, 1'b1, '1, '1, '1, 1, 1,
            mk_beat(KIND_DONE, 1'b0, '0, 1'b0, 0, 1'b1));
    add_row(OP_SPARE_7, 1'b1, '1, '1, '1, 1, 1,
            mk_beat(KIND_DONE, 1'b0, '0, 1'b0, 0, 1'b1));
    add_row(OP_TICK,    1'b0, '0, '0, '0, 1, 1,
            mk_beat(KIND_DONE, 1'b0, '0, 1'b0, 0, 1'b1));
    // schedules: longest delay, zero delay (held until cancelled), short ones
    add_row(OP_SCHED,   1'b1, '1, '1, '0, 1, 1,
            mk_beat(KIND_DONE, 1'b0, '0, 1'b0, 0, 1'b1));
    add_row(OP_SCHED,   1'b0, '0, '0, '0, 1, 1,
            mk_beat(KIND_DONE, 1'b0, '0, 1'b0, 0, 1'b1));
    add_row(OP_SCHED,   1'b1, 31'd1, 16'h1234, '0, 1, 1,
            mk_beat(KIND_DONE, 1'b0, '0, 1'b0, 0, 1'b1));
    add_row(OP_SCHED,   1'b0, 31'd2, '1, '0, 1, 1,
            mk_beat(KIND_DONE, 1'b0, '0, 1'b0, 0, 1'b1));
    add_row(OP_TICK,    1'b0, '0, '0, '0, 1, 0, '0);
    add_row(OP_EXISTS,  1'b0, '0, '1, '0, 1, 0, '0);
    add_row(OP_LIST,    1'b0, '0, '0, '0, 1, 1,
            mk_beat(KIND_DONE, 1'b0, '0, 1'b0, 0, 1'b1));
    add_row(OP_LIST,    1'b0, '0, '0, 6'd32, 1, 0, '0);
    add_row(OP_CANCEL,  1'b0, '0, '1, '0, 1, 0, '0);
    add_row(OP_COUNT,   1'b0, '0, '0, '0, 1, 0, '0);
    // fill the table, then overflow it
    add_row(OP_SCHED,   1'b1, 31'd3, 16'h00A5, '0, 31, 0, '0);
    add_row(OP_SCHED,   1'b0, 31'd5, 16'h0777, '0, 1, 1,
            mk_beat(KIND_FULL, 1'b0, '0, 1'b0, 0, 1'b1));
    add_row(OP_LIST,    1'b0, '0, '0, 6'd40, 1, 0, '0);
    add_row(OP_COUNT,   1'b0, '0, '0, '0, 1, 0, '0);
    // mass expiry, then run up to the housekeeping wrap
    add_row(OP_TICK,    1'b0, '0, '0, '0, 3, 0, '0);
    add_row(OP_TICK,    1'b0, '0, '0, '0, 11, 0, '0);
    add_row(OP_EXISTS,  1'b0, '0, '0, '0, 1, 0, '0);
    add_row(OP_CANCEL,  1'b0, '0, '0, '0, 1, 0, '0);
    add_row(OP_CANCEL,  1'b0, '0, 16'h5A5A, '0, 1, 0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      repeat (plan[k].reps) send_cmd(plan[k].c, plan[k].typed, plan[k].want);
    end

    // random traffic in three idling phases
    for (int k = 0; k < 163; k++) begin
      idle_pct = (k < 54) ? 6 : (k < 108) ? 78 : 0;
      send_cmd(random_cmd(), 1'b0, '0);
    end
    start <= 1'b0;

    while (due_beats.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && due_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule
